/* rtl/rbsi_pkg.sv */
// shared types, constants and the divider step for the x-z slab intersection block
`timescale 1ns / 1ps

package rbsi_pkg;

  // fixed point format
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DW        = 32;
  // quotient bits kept before saturation, one divider stage per bit
  localparam int unsigned QW        = DW + 1;
  // number of slab divisions per item: x low, x high, z low, z high
  localparam int unsigned NLANE     = 4;

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // face codes
  localparam logic [2:0] FACE_NONE = 3'd0;
  localparam logic [2:0] FACE_PX   = 3'd1;
  localparam logic [2:0] FACE_NX   = 3'd2;
  localparam logic [2:0] FACE_PZ   = 3'd3;
  localparam logic [2:0] FACE_NZ   = 3'd4;

  typedef struct packed {
    logic signed [DW-1:0] origin_x;
    logic signed [DW-1:0] origin_y;
    logic signed [DW-1:0] origin_z;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    logic signed [DW-1:0] box_min_x;
    logic signed [DW-1:0] box_min_z;
    logic signed [DW-1:0] box_max_x;
    logic signed [DW-1:0] box_max_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [DW-1:0] t_enter;
    logic signed [DW-1:0] contact_x;
    logic signed [DW-1:0] contact_y;
    logic signed [DW-1:0] contact_z;
    logic [2:0]           face_code;
  } out_t;

  // ray data and zero-direction flags carried alongside the arithmetic
  typedef struct packed {
    in_t  item;
    logic zero_x;
    logic zero_z;
    logic inside_x;
    logic inside_z;
  } side_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] quo;
    logic [QW-1:0] num;
    logic [DW-1:0] den;
    logic          neg;
    logic          ovf;
  } div_t;

  // one quotient bit: shift in the next numerator bit, subtract if it fits
  function automatic div_t div_step(div_t s);
    div_t          r;
    logic [DW:0]   part;
    logic [DW:0]   diff;
    logic          fits;
    r    = s;
    part = {s.rem, s.num[QW-1]};
    diff = part - {1'b0, s.den};
    fits = (part >= {1'b0, s.den});
    r.rem = fits ? diff[DW-1:0] : part[DW-1:0];
    r.quo = {s.quo[QW-2:0], fits};
    r.num = {s.num[QW-2:0], 1'b0};
    return r;
  endfunction

endpackage

/* rtl/ray_box_slab_intersect_xz.sv */
// top level: pipelined ray versus box footprint slab test in the x-z plane
`timescale 1ns / 1ps

// Takes one ray and box footprint per beat and returns one result beat per
// input beat, in order. The pipeline accepts a new beat every cycle unless
// the output is stalled; its length is set mostly by the bit-per-stage
// restoring dividers that form the four slab parameters in parallel. The
// whole pipeline holds while a finished result waits at the output, so
// in_ready_o follows out_ready_i whenever the output register is full.
// Values are signed fixed point with rbsi_pkg::FRAC_BITS fraction bits.
module ray_box_slab_intersect_xz (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rbsi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rbsi_pkg::out_t out_data_o
);

  localparam int unsigned DW = rbsi_pkg::DW;
  localparam int unsigned QW = rbsi_pkg::QW;
  localparam int unsigned F  = rbsi_pkg::FRAC_BITS;
  localparam int unsigned NL = rbsi_pkg::NLANE;
  localparam int unsigned NW = DW + 1 + F;

  logic en;
  logic out_valid_q;
  rbsi_pkg::out_t out_q, out_d;

  // whole pipeline advances unless the output beat is stalled
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage a: differences and zero-direction checks
  rbsi_pkg::side_t        side_a_d, side_a_q;
  logic signed [DW:0]     diff_a_d [NL];
  logic signed [DW:0]     diff_a_q [NL];
  logic                   valid_a_q;

  always_comb begin
    side_a_d.item     = in_data_i;
    side_a_d.zero_x   = (in_data_i.dir_x == '0);
    side_a_d.zero_z   = (in_data_i.dir_z == '0);
    side_a_d.inside_x = (in_data_i.box_min_x <= in_data_i.origin_x) &&
                        (in_data_i.origin_x <= in_data_i.box_max_x);
    side_a_d.inside_z = (in_data_i.box_min_z <= in_data_i.origin_z) &&
                        (in_data_i.origin_z <= in_data_i.box_max_z);
    diff_a_d[0] = $signed({in_data_i.box_min_x[DW-1], in_data_i.box_min_x}) -
                  $signed({in_data_i.origin_x[DW-1], in_data_i.origin_x});
    diff_a_d[1] = $signed({in_data_i.box_max_x[DW-1], in_data_i.box_max_x}) -
                  $signed({in_data_i.origin_x[DW-1], in_data_i.origin_x});
    diff_a_d[2] = $signed({in_data_i.box_min_z[DW-1], in_data_i.box_min_z}) -
                  $signed({in_data_i.origin_z[DW-1], in_data_i.origin_z});
    diff_a_d[3] = $signed({in_data_i.box_max_z[DW-1], in_data_i.box_max_z}) -
                  $signed({in_data_i.origin_z[DW-1], in_data_i.origin_z});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q <= side_a_d;
      diff_a_q <= diff_a_d;
    end
  end

  // stage b: magnitudes and quotient signs
  rbsi_pkg::side_t side_b_q;
  logic [DW:0]     mag_b_q [NL];
  logic [DW-1:0]   den_b_q [NL];
  logic            neg_b_q [NL];
  logic            valid_b_q;
  logic [DW:0]     mag_b_d [NL];
  logic [DW-1:0]   den_b_d [NL];
  logic            neg_b_d [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      logic signed [DW-1:0] dir;
      dir = (i < 2) ? side_a_q.item.dir_x : side_a_q.item.dir_z;
      mag_b_d[i] = diff_a_q[i][DW] ? (DW+1)'(-diff_a_q[i]) : diff_a_q[i];
      den_b_d[i] = dir[DW-1] ? DW'(-dir) : dir;
      neg_b_d[i] = diff_a_q[i][DW] ^ dir[DW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (en) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_b_q <= side_a_q;
      mag_b_q  <= mag_b_d;
      den_b_q  <= den_b_d;
      neg_b_q  <= neg_b_d;
    end
  end

  // divider setup: overflow check on the high numerator part
  rbsi_pkg::side_t side_p_q [QW+1];
  rbsi_pkg::div_t  div_q    [QW+1][NL];
  logic            valid_p_q[QW+1];
  rbsi_pkg::div_t  div_init [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      logic [NW-1:0] numer;
      numer = {mag_b_q[i], {F{1'b0}}};
      div_init[i].rem = DW'(numer[NW-1:QW]);
      div_init[i].quo = '0;
      div_init[i].num = numer[QW-1:0];
      div_init[i].den = den_b_q[i];
      div_init[i].neg = neg_b_q[i];
      div_init[i].ovf = (DW'(numer[NW-1:QW]) >= den_b_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q[0] <= 1'b0;
    end else if (en) begin
      valid_p_q[0] <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_p_q[0] <= side_b_q;
      div_q[0]    <= div_init;
    end
  end

  // divider stages, one quotient bit each
  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_p_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_p_q[k+1] <= valid_p_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_p_q[k+1] <= side_p_q[k];
        for (int i = 0; i < NL; i++) begin
          div_q[k+1][i] <= rbsi_pkg::div_step(div_q[k][i]);
        end
      end
    end
  end

  // stage s: sign and saturate the quotients
  rbsi_pkg::side_t      side_s_q;
  logic signed [DW-1:0] t_s_q [NL];
  logic signed [DW-1:0] t_s_d [NL];
  logic                 valid_s_q;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      rbsi_pkg::div_t r;
      r = div_q[QW][i];
      if (r.neg) begin
        if (r.ovf || r.quo > QW'({1'b1, {(DW-1){1'b0}}})) begin
          t_s_d[i] = rbsi_pkg::SAT_MIN;
        end else begin
          t_s_d[i] = DW'(-r.quo);
        end
      end else begin
        if (r.ovf || r.quo > QW'(rbsi_pkg::SAT_MAX)) begin
          t_s_d[i] = rbsi_pkg::SAT_MAX;
        end else begin
          t_s_d[i] = r.quo[DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s_q <= 1'b0;
    end else if (en) begin
      valid_s_q <= valid_p_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_s_q <= side_p_q[QW];
      t_s_q    <= t_s_d;
    end
  end

  // stage o: order each slab, unbounded slab for a zero direction
  rbsi_pkg::side_t      side_o_q;
  logic signed [DW-1:0] nx_o_q, fx_o_q, nz_o_q, fz_o_q;
  logic signed [DW-1:0] nx_o_d, fx_o_d, nz_o_d, fz_o_d;
  logic                 miss_o_q, miss_o_d;
  logic                 valid_o_q;

  always_comb begin
    miss_o_d = 1'b0;
    if (side_s_q.zero_x) begin
      nx_o_d   = rbsi_pkg::SAT_MIN;
      fx_o_d   = rbsi_pkg::SAT_MAX;
      miss_o_d = !side_s_q.inside_x;
    end else if (t_s_q[0] > t_s_q[1]) begin
      nx_o_d = t_s_q[1];
      fx_o_d = t_s_q[0];
    end else begin
      nx_o_d = t_s_q[0];
      fx_o_d = t_s_q[1];
    end
    if (side_s_q.zero_z) begin
      nz_o_d   = rbsi_pkg::SAT_MIN;
      fz_o_d   = rbsi_pkg::SAT_MAX;
      miss_o_d = miss_o_d || !side_s_q.inside_z;
    end else if (t_s_q[2] > t_s_q[3]) begin
      nz_o_d = t_s_q[3];
      fz_o_d = t_s_q[2];
    end else begin
      nz_o_d = t_s_q[2];
      fz_o_d = t_s_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o_q <= 1'b0;
    end else if (en) begin
      valid_o_q <= valid_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_o_q <= side_s_q;
      nx_o_q   <= nx_o_d;
      fx_o_q   <= fx_o_d;
      nz_o_q   <= nz_o_d;
      fz_o_q   <= fz_o_d;
      miss_o_q <= miss_o_d;
    end
  end

  // stage c: combine the intervals, pick the face
  rbsi_pkg::side_t      side_c_q;
  logic signed [DW-1:0] tn_c_q, tn_c_d, tf_c_d;
  logic [2:0]           face_c_q, face_c_d;
  logic                 miss_c_q, miss_c_d;
  logic                 valid_c_q;

  always_comb begin
    tn_c_d   = (nx_o_q > nz_o_q) ? nx_o_q : nz_o_q;
    tf_c_d   = (fx_o_q < fz_o_q) ? fx_o_q : fz_o_q;
    miss_c_d = miss_o_q || (nx_o_q > fz_o_q) || (nz_o_q > fx_o_q) || tf_c_d[DW-1];
    if (nx_o_q > nz_o_q) begin
      face_c_d = side_o_q.item.dir_x[DW-1] ? rbsi_pkg::FACE_PX : rbsi_pkg::FACE_NX;
    end else if (nx_o_q < nz_o_q) begin
      face_c_d = side_o_q.item.dir_z[DW-1] ? rbsi_pkg::FACE_PZ : rbsi_pkg::FACE_NZ;
    end else begin
      face_c_d = rbsi_pkg::FACE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else if (en) begin
      valid_c_q <= valid_o_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_c_q <= side_o_q;
      tn_c_q   <= tn_c_d;
      face_c_q <= face_c_d;
      miss_c_q <= miss_c_d;
    end
  end

  // stage m: direction times entry parameter
  rbsi_pkg::side_t        side_m_q;
  logic signed [DW-1:0]   tn_m_q;
  logic [2:0]             face_m_q;
  logic                   miss_m_q;
  logic signed [2*DW-1:0] px_m_q, py_m_q, pz_m_q;
  logic                   valid_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
    end else if (en) begin
      valid_m_q <= valid_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_m_q <= side_c_q;
      tn_m_q   <= tn_c_q;
      face_m_q <= face_c_q;
      miss_m_q <= miss_c_q;
      px_m_q   <= side_c_q.item.dir_x * tn_c_q;
      py_m_q   <= side_c_q.item.dir_y * tn_c_q;
      pz_m_q   <= side_c_q.item.dir_z * tn_c_q;
    end
  end

  // output stage: floor shift, add origin, saturate
  function automatic logic signed [DW-1:0] contact(logic signed [DW-1:0] org,
                                                    logic signed [2*DW-1:0] prod);
    logic signed [2*DW-1:0] sh;
    logic signed [2*DW:0]   sum;
    sh  = prod >>> F;
    sum = $signed({org[DW-1], {DW{org[DW-1]}}, org}) + $signed({sh[2*DW-1], sh});
    if (sum > $signed((2*DW+1)'(rbsi_pkg::SAT_MAX))) begin
      return rbsi_pkg::SAT_MAX;
    end else if (sum < $signed({{(DW+1){1'b1}}, rbsi_pkg::SAT_MIN})) begin
      return rbsi_pkg::SAT_MIN;
    end
    return sum[DW-1:0];
  endfunction

  always_comb begin
    out_d = '0;
    if (!miss_m_q) begin
      out_d.hit       = 1'b1;
      out_d.t_enter   = tn_m_q;
      out_d.contact_x = contact(side_m_q.item.origin_x, px_m_q);
      out_d.contact_y = contact(side_m_q.item.origin_y, py_m_q);
      out_d.contact_z = contact(side_m_q.item.origin_z, pz_m_q);
      out_d.face_code = face_m_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/rbsi_checker.sv */
// port-level checks for the slab intersection block and their bind
`timescale 1ns / 1ps

module rbsi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rbsi_pkg::out_t out_data_o
);

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      out_data_o.t_enter == '0 && out_data_o.contact_x == '0 &&
      out_data_o.contact_y == '0 && out_data_o.contact_z == '0 &&
      out_data_o.face_code == rbsi_pkg::FACE_NONE)
    else $error("miss with nonzero fields");

  // face codes stay within the defined set
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.face_code <= rbsi_pkg::FACE_NZ)
    else $error("undefined face code");

endmodule

bind ray_box_slab_intersect_xz rbsi_checker u_rbsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
